>>> hw/rtl/cdi_pkg.sv
// shared types, constants and divider reciprocals for the disc id block
package cdi_pkg;

	// track limit and derived counter width
	localparam int MAX_TRACKS = 99;
	localparam int TRACK_W    = $clog2(MAX_TRACKS + 1);

	// field widths
	localparam int FRAME_W = 19;
	localparam int SECS_W  = 13;
	localparam int QSUM_W  = 10;
	localparam int DSUM_W  = 6;
	localparam int CSUM_W  = 8;

	// checksum modulus
	localparam int CSUM_MOD = 255;

	// reciprocal multipliers for division by constants
	localparam logic [18:0] DIV75_MUL   = 19'd447393;
	localparam int          DIV75_SH    = 25;
	localparam logic [12:0] DIV10_MUL   = 13'd6554;
	localparam int          DIV10_SH    = 16;
	localparam logic [12:0] DIV100_MUL  = 13'd5243;
	localparam int          DIV100_SH   = 19;
	localparam logic [13:0] DIV1000_MUL = 14'd8389;
	localparam int          DIV1000_SH  = 23;

	// queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);
	localparam int OCC_W  = QCNT_W + 1;

	typedef enum logic {
		CMD_TRACK   = 1'b0,
		CMD_LEADOUT = 1'b1
	} cmd_t;

	typedef struct packed {
		cmd_t               command;
		logic [FRAME_W-1:0] frame;
	} item_t;

	typedef struct packed {
		logic [31:0]  disc_id;
		logic [6:0]   track_count;
		logic         too_many_tracks;
	} result_t;

	// classified word handed from front to back
	typedef struct packed {
		cmd_t              command;
		logic [SECS_W-1:0] secs;
		logic [QSUM_W-1:0] qsum;
	} work_t;

	typedef struct packed {
		logic  valid;
		work_t work;
	} qword_t;

endpackage

>>> hw/rtl/cddb_disc_id.sv
// top level of the disc id block: front end, queue and back end
//
//   channel  dir  handshake            word
//   item     in   item_valid/stall     command, frame
//   id       out  id_valid/stall       disc_id, track_count, too_many_tracks
//
// one word per cycle sustained while the result channel is not stalled; a track word causes no result
// a lead-out result is registered through both front end stages, the queue write and
// the output register
// reset clears counters and flags at once, no clearing pass
// a stalled result holds the next lead-out at the queue head; the four-entry
// queue then fills and item_stall rises
module cddb_disc_id (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  cdi_pkg::item_t    item,
	output logic              id_valid,
	input  logic              id_stall,
	output cdi_pkg::result_t  id
);

	cdi_pkg::qword_t             push;
	cdi_pkg::qword_t             head;
	logic                        pop;
	logic [cdi_pkg::QCNT_W-1:0]  level;

	// accept and classify
	cdi_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.level      (level),
		.push       (push)
	);

	// decoupling queue
	cdi_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.level  (level)
	);

	// accumulate and emit
	cdi_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.pop      (pop),
		.id_valid (id_valid),
		.id_stall (id_stall),
		.id       (id)
	);

endmodule

>>> hw/rtl/cdi_front.sv
// front end: accepts words, converts frames to seconds, prepares digit sum terms
module cdi_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      item_valid,
	output logic                      item_stall,
	input  cdi_pkg::item_t            item,
	input  logic [cdi_pkg::QCNT_W-1:0] level,
	output cdi_pkg::qword_t           push
);

	logic                          accept;
	logic [cdi_pkg::OCC_W-1:0]     occupancy;
	logic [37:0]                   prod75;
	logic [25:0]                   prod10;
	logic [25:0]                   prod100;
	logic [26:0]                   prod1000;
	logic [cdi_pkg::QSUM_W-1:0]    qsum;

	logic                          valid_s1;
	cdi_pkg::cmd_t                 cmd_s1;
	logic [cdi_pkg::SECS_W-1:0]    secs_s1;
	logic                          valid_s2;
	cdi_pkg::cmd_t                 cmd_s2;
	logic [cdi_pkg::SECS_W-1:0]    secs_s2;
	logic [cdi_pkg::QSUM_W-1:0]    qsum_s2;

	// credit check: queued words plus words in flight must leave a free slot
	always_comb begin
		occupancy  = cdi_pkg::OCC_W'(level) + cdi_pkg::OCC_W'(valid_s1)
		           + cdi_pkg::OCC_W'(valid_s2);
		item_stall = occupancy >= cdi_pkg::OCC_W'(cdi_pkg::QDEPTH);
		accept     = item_valid && !item_stall;
	end

	// frames to seconds by reciprocal multiply
	assign prod75 = 38'(item.frame) * 38'(cdi_pkg::DIV75_MUL);

	// seconds over 10, 100, 1000; digit sum is secs - 9 * (sum of quotients)
	always_comb begin
		prod10   = 26'(secs_s1) * 26'(cdi_pkg::DIV10_MUL);
		prod100  = 26'(secs_s1) * 26'(cdi_pkg::DIV100_MUL);
		prod1000 = 27'(secs_s1) * 27'(cdi_pkg::DIV1000_MUL);
		qsum     = cdi_pkg::QSUM_W'(prod10[cdi_pkg::DIV10_SH +: 10])
		         + cdi_pkg::QSUM_W'(prod100[cdi_pkg::DIV100_SH +: 7])
		         + cdi_pkg::QSUM_W'(prod1000[cdi_pkg::DIV1000_SH +: 4]);
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1  <= item.command;
			secs_s1 <= prod75[cdi_pkg::DIV75_SH +: cdi_pkg::SECS_W];
		end
		if (valid_s1) begin
			cmd_s2  <= cmd_s1;
			secs_s2 <= secs_s1;
			qsum_s2 <= qsum;
		end
	end

	// word into the queue
	always_comb begin
		push.valid        = valid_s2;
		push.work.command = cmd_s2;
		push.work.secs    = secs_s2;
		push.work.qsum    = qsum_s2;
	end

endmodule

>>> hw/rtl/cdi_queue.sv
// short queue decoupling the front end from the accumulator
module cdi_queue (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cdi_pkg::qword_t            push,
	input  logic                       pop,
	output cdi_pkg::qword_t            head,
	output logic [cdi_pkg::QCNT_W-1:0] level
);

	cdi_pkg::work_t                mem_q [cdi_pkg::QDEPTH];
	logic [cdi_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [cdi_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [cdi_pkg::QCNT_W-1:0]    count_q;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push.valid && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push.valid && pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_ptr_q] <= push.work;
		end
	end

	// head of queue
	always_comb begin
		head.valid = count_q != '0;
		head.work  = mem_q[rd_ptr_q];
		level      = count_q;
	end

	// credit scheme must never push into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> count_q < cdi_pkg::QCNT_W'(cdi_pkg::QDEPTH))
		else $error("push into full queue");

	// pops only from a non-empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("pop from empty queue");

endmodule

>>> hw/rtl/cdi_back.sv
// back end: accumulates checksum and track state, builds the disc id
module cdi_back (
	input  logic              clk,
	input  logic              arst_n,
	input  cdi_pkg::qword_t   head,
	output logic              pop,
	output logic              id_valid,
	input  logic              id_stall,
	output cdi_pkg::result_t  id
);

	logic [cdi_pkg::CSUM_W-1:0]  checksum_q;
	logic [cdi_pkg::TRACK_W-1:0] tracks_q;
	logic [cdi_pkg::SECS_W-1:0]  first_q;
	logic                        overflow_q;
	logic                        valid_q;
	cdi_pkg::result_t            id_q;

	logic                        is_lead;
	logic                        take_track;
	logic                        load;
	logic [cdi_pkg::SECS_W-1:0]  qsum_x9;
	logic [cdi_pkg::SECS_W-1:0]  dsum_full;
	logic [cdi_pkg::DSUM_W-1:0]  dsum;
	logic [8:0]                  sum9;
	logic [cdi_pkg::CSUM_W-1:0]  csum_next;
	logic [31:0]                 span;
	cdi_pkg::result_t            result;

	// pop control: lead-out waits for room in the output register
	always_comb begin
		is_lead    = head.work.command == cdi_pkg::CMD_LEADOUT;
		pop        = head.valid && (!is_lead || !valid_q || !id_stall);
		load       = pop && is_lead;
		take_track = pop && !is_lead &&
		             (tracks_q < cdi_pkg::TRACK_W'(cdi_pkg::MAX_TRACKS));
	end

	// digit sum and checksum mod 255
	always_comb begin
		qsum_x9   = (cdi_pkg::SECS_W'(head.work.qsum) << 3)
		          + cdi_pkg::SECS_W'(head.work.qsum);
		dsum_full = head.work.secs - qsum_x9;
		dsum      = dsum_full[cdi_pkg::DSUM_W-1:0];
		sum9      = 9'(checksum_q) + 9'(dsum);
		if (sum9 >= 9'(cdi_pkg::CSUM_MOD)) begin
			sum9 = sum9 - 9'(cdi_pkg::CSUM_MOD);
		end
		csum_next = sum9[cdi_pkg::CSUM_W-1:0];
	end

	// disc id assembly
	always_comb begin
		span = 32'(head.work.secs) - 32'(first_q);
		result.disc_id = '0;
		if (tracks_q != '0) begin
			result.disc_id = {checksum_q, 24'd0} | (span << 8) | {24'd0, 8'(tracks_q)};
		end
		result.track_count     = 7'(tracks_q);
		result.too_many_tracks = overflow_q;
	end

	// per-disc state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			checksum_q <= '0;
			tracks_q   <= '0;
			first_q    <= '0;
			overflow_q <= 1'b0;
		end else if (load) begin
			checksum_q <= '0;
			tracks_q   <= '0;
			first_q    <= '0;
			overflow_q <= 1'b0;
		end else if (take_track) begin
			checksum_q <= csum_next;
			tracks_q   <= tracks_q + 1'b1;
			if (tracks_q == '0) begin
				first_q <= head.work.secs;
			end
		end else if (pop) begin
			overflow_q <= 1'b1;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!id_stall) begin
			valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (load) begin
			id_q <= result;
		end
	end

	assign id_valid = valid_q;
	assign id       = id_q;

	// track counter never passes the limit
	a_track_limit: assert property (@(posedge clk) disable iff (!arst_n)
		tracks_q <= cdi_pkg::TRACK_W'(cdi_pkg::MAX_TRACKS))
		else $error("track counter above limit");

	// a lead-out clears the disc state
	a_leadout_clears: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (tracks_q == '0) && !overflow_q && (checksum_q == '0))
		else $error("state not cleared after lead-out");

	// overflow only once the limit is reached
	a_overflow_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		overflow_q |-> tracks_q == cdi_pkg::TRACK_W'(cdi_pkg::MAX_TRACKS))
		else $error("overflow flag below track limit");

endmodule

>>> verif/cddb_disc_id_tb.sv
// self-checking testbench for the disc id block: directed table, random discs, stalls
`timescale 1ns / 100ps

module cddb_disc_id_tb;

	localparam int FRAMES_PER_SEC = 75;
	localparam int DIGIT_BASE     = 10;
	localparam int MAX_FRAME      = 449999;

	// one row of the directed table
	typedef struct {
		cdi_pkg::item_t   w;
		bit               typed;
		cdi_pkg::result_t want;
	} plan_row_t;

	logic             clk        = 1'b0;
	logic             arst_n     = 1'b0;
	logic             item_valid = 1'b0;
	logic             item_stall;
	cdi_pkg::item_t   item       = '0;
	logic             id_valid;
	logic             id_stall   = 1'b0;
	cdi_pkg::result_t id;

	// idle and stall odds in percent, and the long receiver hold-off
	int unsigned idle_pct  = 0;
	int unsigned stall_pct = 0;
	bit          hold_on   = 1'b0;

	// disc state as the block should hold it
	int unsigned csum_acc;
	int unsigned tracks_acc;
	int unsigned first_secs_acc;
	int unsigned over_acc;

	cdi_pkg::result_t pending_ids[$];
	int unsigned mismatches    = 0;
	int unsigned words_taken   = 0;
	int unsigned ids_queued    = 0;
	int unsigned ids_checked   = 0;
	int unsigned overflow_ids  = 0;
	int unsigned wrapped_ids   = 0;
	int unsigned disc_no       = 0;
	int unsigned big_no        = 0;

	cddb_disc_id dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.id_valid   (id_valid),
		.id_stall   (id_stall),
		.id         (id)
	);

	always #5 clk = ~clk;

	// decimal digit sum of a seconds count
	function automatic int unsigned digit_total(input int unsigned n);
		int unsigned s;
		s = 0;
		while (n > 0) begin
			s += n % DIGIT_BASE;
			n /= DIGIT_BASE;
		end
		return s;
	endfunction

	// advance the disc state by one word; returns 1 when a disc id falls out
	function automatic bit disc_id_predict(input cdi_pkg::item_t w,
			output cdi_pkg::result_t r);
		int unsigned secs;
		int unsigned span;
		secs = w.frame / FRAMES_PER_SEC;
		r = '0;
		if (w.command == cdi_pkg::CMD_TRACK) begin
			if (tracks_acc >= cdi_pkg::MAX_TRACKS) begin
				over_acc = 1;
			end else begin
				if (tracks_acc == 0)
					first_secs_acc = secs;
				csum_acc = (csum_acc + digit_total(secs)) % cdi_pkg::CSUM_MOD;
				tracks_acc++;
			end
			return 1'b0;
		end
		if (tracks_acc != 0) begin
			span = secs - first_secs_acc;
			if (secs < first_secs_acc)
				wrapped_ids++;
			r.disc_id = (csum_acc << 24) | (span << 8) | (tracks_acc & 32'hFF);
		end
		r.track_count     = tracks_acc[6:0];
		r.too_many_tracks = over_acc[0];
		if (over_acc != 0)
			overflow_ids++;
		csum_acc       = 0;
		tracks_acc     = 0;
		first_secs_acc = 0;
		over_acc       = 0;
		return 1'b1;
	endfunction

	function automatic plan_row_t plan_row(input cdi_pkg::cmd_t c, input int unsigned f,
			input bit typed, input logic [31:0] did, input logic [6:0] cnt,
			input logic flag);
		plan_row_t p;
		p.w.command            = c;
		p.w.frame              = cdi_pkg::FRAME_W'(f);
		p.typed                = typed;
		p.want.disc_id         = did;
		p.want.track_count     = cnt;
		p.want.too_many_tracks = flag;
		return p;
	endfunction

	task automatic miss(input string what, input logic [31:0] want, input logic [31:0] got);
		if (mismatches < 10)
			$display("mismatch %s: expected %h got %h at %0t", what, want, got, $time);
		mismatches++;
	endtask

	// offer one word with random idle cycles ahead of it, then book its disc id if any
	task automatic send_word(input cdi_pkg::item_t w, input bit typed,
			input cdi_pkg::result_t want);
		cdi_pkg::result_t r;
		while ($urandom_range(99) < idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= w;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		words_taken++;
		if (disc_id_predict(w, r)) begin
			pending_ids.push_back(typed ? want : r);
			ids_queued++;
		end
	endtask

	// pause the sender until every pending disc id has come out
	task automatic drain_ids();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending_ids.size() != 0)
			@(posedge clk);
	endtask

	// one random disc: mostly rising track offsets, a few stray words, then a lead-out
	task automatic send_disc();
		int unsigned n;
		int unsigned pos;
		int unsigned step_max;
		cdi_pkg::item_t w;
		if (disc_no % 12 == 5) begin
			n = 98 + big_no % 4;
			big_no++;
		end else if ($urandom_range(9) == 0) begin
			n = 0;
		end else begin
			n = $urandom_range(1, 15);
		end
		disc_no++;
		step_max = (n > 20) ? 4000 : 30000;
		pos = $urandom_range(0, 400);
		for (int k = 0; k < n; k++) begin
			// stray word, may close the disc early
			if ($urandom_range(19) == 0) begin
				w.command = cdi_pkg::cmd_t'($urandom_range(1));
				w.frame   = cdi_pkg::FRAME_W'($urandom);
				send_word(w, 1'b0, '0);
			end
			w.command = cdi_pkg::CMD_TRACK;
			if ($urandom_range(15) == 0) begin
				w.frame = cdi_pkg::FRAME_W'($urandom);
			end else begin
				pos += $urandom_range(0, step_max);
				if (pos > MAX_FRAME)
					pos = $urandom_range(0, MAX_FRAME);
				w.frame = cdi_pkg::FRAME_W'(pos);
			end
			send_word(w, 1'b0, '0);
		end
		// lead-out, now and then anywhere in the 19-bit range
		w.command = cdi_pkg::CMD_LEADOUT;
		if ($urandom_range(7) == 0) begin
			w.frame = cdi_pkg::FRAME_W'($urandom);
		end else begin
			pos += $urandom_range(0, 30000);
			w.frame = cdi_pkg::FRAME_W'((pos > MAX_FRAME) ? MAX_FRAME : pos);
		end
		send_word(w, 1'b0, '0);
	endtask

	task automatic run_discs(input int unsigned word_goal, input int unsigned id_goal);
		int unsigned w0;
		int unsigned i0;
		w0 = words_taken;
		i0 = ids_queued;
		while ((words_taken - w0 < word_goal || ids_queued - i0 < id_goal)
				&& words_taken - w0 < 3000)
			send_disc();
	endtask

	task automatic hold_receiver(input int unsigned cycles);
		hold_on = 1'b1;
		repeat (cycles) @(posedge clk);
		hold_on = 1'b0;
	endtask

	// receiver stall
	always @(posedge clk)
		id_stall <= hold_on || ($urandom_range(99) < stall_pct);

	// compare each taken disc id with the oldest pending one
	always @(posedge clk) begin
		cdi_pkg::result_t want;
		if (arst_n && id_valid && !id_stall) begin
			ids_checked++;
			if (pending_ids.size() == 0) begin
				miss("disc id with nothing pending", '0, id.disc_id);
			end else begin
				want = pending_ids.pop_front();
				if (id.disc_id !== want.disc_id)
					miss("disc_id", want.disc_id, id.disc_id);
				if (id.track_count !== want.track_count)
					miss("track_count", 32'(want.track_count), 32'(id.track_count));
				if (id.too_many_tracks !== want.too_many_tracks)
					miss("too_many_tracks", 32'(want.too_many_tracks),
						32'(id.too_many_tracks));
			end
		end
	end

	// stimulus
	initial begin
		plan_row_t plan[$];
		csum_acc       = 0;
		tracks_acc     = 0;
		first_secs_acc = 0;
		over_acc       = 0;

		// empty discs, single tracks at the frame extremes, short multi-track discs, wrapped spans
		plan.push_back(plan_row(cdi_pkg::CMD_LEADOUT, 0, 1'b1, 32'h0, 7'd0, 1'b0));
		plan.push_back(plan_row(cdi_pkg::CMD_LEADOUT, 524287, 1'b1, 32'h0, 7'd0, 1'b0));
		plan.push_back(plan_row(cdi_pkg::CMD_TRACK, 0, 1'b0, '0, '0, 1'b0));
		plan.push_back(plan_row(cdi_pkg::CMD_LEADOUT, 0, 1'b1, 32'h0000_0001, 7'd1, 1'b0));
		plan.push_back(plan_row(cdi_pkg::CMD_TRACK, MAX_FRAME, 1'b0, '0, '0, 1'b0));
		plan.push_back(plan_row(cdi_pkg::CMD_LEADOUT, MAX_FRAME, 1'b1, 32'h2000_0001,
			7'd1, 1'b0));
		plan.push_back(plan_row(cdi_pkg::CMD_TRACK, 74, 1'b0, '0, '0, 1'b0));
		plan.push_back(plan_row(cdi_pkg::CMD_TRACK, 75, 1'b0, '0, '0, 1'b0));
		plan.push_back(plan_row(cdi_pkg::CMD_LEADOUT, 150, 1'b1, 32'h0100_0202, 7'd2, 1'b0));
		plan.push_back(plan_row(cdi_pkg::CMD_TRACK, 524287, 1'b0, '0, '0, 1'b0));
		plan.push_back(plan_row(cdi_pkg::CMD_LEADOUT, 0, 1'b0, '0, '0, 1'b0));
		plan.push_back(plan_row(cdi_pkg::CMD_TRACK, 75000, 1'b0, '0, '0, 1'b0));
		plan.push_back(plan_row(cdi_pkg::CMD_LEADOUT, 7500, 1'b0, '0, '0, 1'b0));
		plan.push_back(plan_row(cdi_pkg::CMD_TRACK, 150, 1'b0, '0, '0, 1'b0));
		plan.push_back(plan_row(cdi_pkg::CMD_TRACK, 18000, 1'b0, '0, '0, 1'b0));
		plan.push_back(plan_row(cdi_pkg::CMD_TRACK, 36725, 1'b0, '0, '0, 1'b0));
		plan.push_back(plan_row(cdi_pkg::CMD_TRACK, 112000, 1'b0, '0, '0, 1'b0));
		plan.push_back(plan_row(cdi_pkg::CMD_LEADOUT, 301000, 1'b0, '0, '0, 1'b0));
		plan.push_back(plan_row(cdi_pkg::CMD_LEADOUT, 1234, 1'b1, 32'h0, 7'd0, 1'b0));
		plan.push_back(plan_row(cdi_pkg::CMD_TRACK, 262144, 1'b0, '0, '0, 1'b0));
		plan.push_back(plan_row(cdi_pkg::CMD_LEADOUT, MAX_FRAME, 1'b0, '0, '0, 1'b0));

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i])
			send_word(plan[i].w, plan[i].typed, plan[i].want);
		drain_ids();

		// back to back words
		idle_pct  = 0;
		stall_pct = 0;
		run_discs(150, 8);

		// receiver holds off while the sender keeps offering words
		fork
			hold_receiver(150);
			run_discs(60, 4);
		join
		drain_ids();

		idle_pct  = 48;
		stall_pct = 0;
		run_discs(180, 10);
		drain_ids();

		idle_pct  = 0;
		stall_pct = 48;
		run_discs(180, 10);
		drain_ids();

		idle_pct  = 36;
		stall_pct = 36;
		run_discs(180, 16);
		drain_ids();

		repeat (20) @(posedge clk);
		$display("sent %0d words, checked %0d disc ids", words_taken, ids_checked);
		$display("%0d ids with ignored tracks, %0d with a wrapped span",
			overflow_ids, wrapped_ids);
		if (mismatches == 0)
			$display("cddb_disc_id_tb OK");
		else
			$display("cddb_disc_id_tb NOT OK");
		$finish;
	end

	// watchdog
	initial begin
		#5000000;
		$display("cddb_disc_id_tb NOT OK");
		$finish;
	end

endmodule

>>> cddb_disc_id.f
hw/rtl/cdi_pkg.sv
hw/rtl/cdi_front.sv
hw/rtl/cdi_queue.sv
hw/rtl/cdi_back.sv
hw/rtl/cddb_disc_id.sv
verif/cddb_disc_id_tb.sv
